>>> rtl/asr_envelope_shaper_assert.svh
// Assertion macros shared by the envelope shaper RTL.
// Each macro takes a label, clock, reset, antecedent and consequent.
`ifndef ASR_ENVELOPE_SHAPER_ASSERT_SVH
`define ASR_ENVELOPE_SHAPER_ASSERT_SVH

// Same-cycle implication.
`define ASR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("asr_envelope_shaper: assertion failed");

// Next-cycle implication.
`define ASR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("asr_envelope_shaper: assertion failed");

`endif

>>> rtl/asr_pkg.sv
// ----------------------------------------------------------------------------
// asr_pkg
// Shared types and constants of the ASR envelope shaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asr_pkg;

   localparam int CHUNK_SIZE = 128;
   localparam int POS_W      = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [23:0] LEVEL_ONE = 24'h800000;

   localparam logic [23:0] ATTACK_STEP_RST   = 24'd17476;
   localparam logic [22:0] RELEASE_ALPHA_RST = 23'd8379875;
   localparam logic [23:0] OFF_CUTOFF_RST    = 24'd419430;

   typedef enum logic [1:0] {
      PH_ATTACK  = 2'd0,
      PH_SUSTAIN = 2'd1,
      PH_RELEASE = 2'd2,
      PH_OFF     = 2'd3
   } phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ATTACK_STEP   = 2'd0,
      CSR_RELEASE_ALPHA = 2'd1,
      CSR_OFF_CUTOFF    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic load;   // latch a present beat, apply chunk-start gate
      logic clear;  // absent beat: reset envelope
      logic mul;    // first product, level update
      logic fin;    // velocity product, round, write output
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

>>> rtl/asr_ctrl.sv
// ----------------------------------------------------------------------------
// asr_ctrl
// Sequencer for load, multiply and output steps of one beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_present,
   output logic                    req_tready,
   input  wire asr_pkg::dp_stat_type stat,
   output asr_pkg::dp_cmd_type     cmd
);
   import asr_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_present) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = accept && req_present;
            cmd.clear  = accept && !req_present;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_OUT: begin
            cmd.fin = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/asr_datapath.sv
// ----------------------------------------------------------------------------
// asr_datapath
// Envelope state, config registers, multiply chain and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asr_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire asr_pkg::dp_cmd_type               cmd,
   output asr_pkg::dp_stat_type                   stat,
   input  wire logic                              csr_we,
   input  wire logic [asr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [asr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic signed [15:0]                sample_in,
   input  wire logic [15:0]                       velocity_in,
   input  wire logic                              gate,
   output logic signed [15:0]                     sample_out,
   output logic [1:0]                             phase_out,
   output logic                                   chunk_last,
   output logic                                   out_valid,
   input  wire logic                              out_ready
);
   import asr_pkg::*;

   localparam logic [POS_W-1:0]    POS_LAST = POS_W'(CHUNK_SIZE - 1);
   localparam logic signed [56:0]  RND_HALF = 57'sh2000000000;  // 2^37

   // config
   logic [23:0] attack_step_ff;
   logic [22:0] release_alpha_ff;
   logic [23:0] off_cutoff_ff;

   // envelope state
   phase_type        phase_ff, phase_in;
   logic [23:0]      env_level_ff, env_level_in;
   logic [15:0]      held_vel_ff, held_vel_in;
   logic [POS_W-1:0] chunk_pos_ff, chunk_pos_in;

   // work registers
   logic signed [15:0] samp_ff;
   logic               last_ff;
   logic               mute_ff;
   logic signed [39:0] prod1_ff;

   // output register
   logic signed [15:0] sample_out_ff;
   logic [1:0]         phase_out_ff;
   logic               last_out_ff;
   logic               out_valid_ff, out_valid_in;

   phase_type          phase_eff;
   logic [23:0]        level_used;
   logic signed [40:0] prod1_full;
   logic [24:0]        atk_sum;
   logic [46:0]        dec_full;
   logic [23:0]        dec_level;
   logic signed [56:0] prod2;
   logic signed [56:0] rnd;
   logic signed [18:0] q;
   logic signed [15:0] sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_step_ff   <= ATTACK_STEP_RST;
         release_alpha_ff <= RELEASE_ALPHA_RST;
         off_cutoff_ff    <= OFF_CUTOFF_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_ATTACK_STEP:   attack_step_ff   <= csr_wdata;
            CSR_RELEASE_ALPHA: release_alpha_ff <= csr_wdata[22:0];
            CSR_OFF_CUTOFF:    off_cutoff_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // chunk-start gate handling
   always_comb begin
      phase_eff   = phase_ff;
      held_vel_in = held_vel_ff;
      if (chunk_pos_ff == '0) begin
         if (gate) begin
            held_vel_in = velocity_in;
            if (phase_ff == PH_RELEASE || phase_ff == PH_OFF) phase_eff = PH_ATTACK;
         end else begin
            if (phase_ff == PH_ATTACK || phase_ff == PH_SUSTAIN) phase_eff = PH_RELEASE;
         end
      end
   end

   assign level_used = (phase_ff == PH_SUSTAIN) ? LEVEL_ONE : env_level_ff;
   assign prod1_full = samp_ff * $signed({1'b0, level_used});
   assign atk_sum    = {1'b0, env_level_ff} + {1'b0, attack_step_ff};
   assign dec_full   = env_level_ff * release_alpha_ff;
   assign dec_level  = dec_full[46:23];

   always_comb begin
      phase_in     = phase_ff;
      env_level_in = env_level_ff;
      chunk_pos_in = chunk_pos_ff;
      if (cmd.clear) begin
         phase_in     = PH_ATTACK;
         env_level_in = '0;
         chunk_pos_in = '0;
      end else if (cmd.load) begin
         phase_in     = phase_eff;
         chunk_pos_in = (chunk_pos_ff == POS_LAST) ? '0 : chunk_pos_ff + 1'b1;
      end else if (cmd.mul) begin
         unique case (phase_ff)
            PH_ATTACK: begin
               if (atk_sum >= {1'b0, LEVEL_ONE}) begin
                  env_level_in = LEVEL_ONE;
                  phase_in     = PH_SUSTAIN;
               end else begin
                  env_level_in = atk_sum[23:0];
               end
            end
            PH_RELEASE: begin
               if (last_ff && (dec_level < off_cutoff_ff)) begin
                  env_level_in = '0;
                  phase_in     = PH_OFF;
               end else begin
                  env_level_in = dec_level;
               end
            end
            PH_SUSTAIN, PH_OFF: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OFF;
         env_level_ff <= '0;
         held_vel_ff  <= '0;
         chunk_pos_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         env_level_ff <= env_level_in;
         chunk_pos_ff <= chunk_pos_in;
         if (cmd.load) held_vel_ff <= held_vel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         samp_ff <= sample_in;
         last_ff <= (chunk_pos_ff == POS_LAST);
      end
      if (cmd.mul) begin
         prod1_ff <= prod1_full[39:0];
         mute_ff  <= (phase_ff == PH_OFF);
      end
   end

   // velocity product, round half up at bit 38, saturate
   assign prod2 = prod1_ff * $signed({1'b0, held_vel_ff});
   assign rnd   = prod2 + RND_HALF;
   assign q     = rnd[56:38];

   always_comb begin
      if (mute_ff)                 sat = '0;
      else if (q > 19'sd32767)     sat = 16'sh7FFF;
      else if (q < -19'sd32768)    sat = 16'sh8000;
      else                         sat = q[15:0];
   end

   assign stat.out_free = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.fin)        out_valid_in = 1'b1;
      else if (out_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin) begin
         sample_out_ff <= sat;
         phase_out_ff  <= phase_ff;
         last_out_ff   <= last_ff;
      end
   end

   assign sample_out = sample_out_ff;
   assign phase_out  = phase_out_ff;
   assign chunk_last = last_out_ff;
   assign out_valid  = out_valid_ff;

endmodule

`default_nettype wire

>>> rtl/asr_envelope_shaper.sv
// ----------------------------------------------------------------------------
// asr_envelope_shaper
// Attack/sustain/release envelope applied to a chunked audio sample stream.
// ----------------------------------------------------------------------------
//
//  channel  | ports                 | payload
//  ---------+-----------------------+------------------------------------------
//  request  | req_tvalid/tready     | tdata: sample_in, velocity_in
//           |                       | tuser: gate, stream_present
//  response | rsp_tvalid/tready     | tdata: sample_out, phase_out; tlast
//  config   | csr_we/addr/wdata     | attack_step, release_alpha, off_cutoff
//
//  A present beat runs in three steps (IDLE, MUL, OUT): accept and gate
//  handling, then sample*level with the level update, then *velocity with
//  round/saturate. The two chained multiplies share one sequencer, which
//  takes no new beat before it is back in IDLE. A beat with stream_present
//  low produces no response. Reset is synchronous; config returns to its
//  default values. A stalled response waits in the output register while
//  the next beat is taken; the sequencer holds in its last step only if it is full.
//
`timescale 1ns / 1ps
`default_nettype none

module asr_envelope_shaper (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [31:0]                    req_tdata,  // [15:0] sample_in, [31:16] velocity_in
   input  wire logic [1:0]                     req_tuser,  // [0] gate, [1] stream_present
   // response
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [23:0]                         rsp_tdata,  // [15:0] sample_out, [17:16] phase_out
   output logic                                rsp_tlast,  // chunk_last
   // config
   input  wire logic                           csr_we,
   input  wire logic [asr_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [asr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import asr_pkg::*;

`include "asr_envelope_shaper_assert.svh"

   dp_cmd_type         ctrl_cmd;
   dp_stat_type        dp_stat;
   logic signed [15:0] sample_out;
   logic [1:0]         phase_out;

   // sequencer: IDLE takes a beat, MUL and OUT run the product chain
   asr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_present (req_tuser[1]),
      .req_tready  (req_tready),
      .stat        (dp_stat),
      .cmd         (ctrl_cmd)
   );

   // envelope state, config, multipliers and response register
   asr_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ctrl_cmd),
      .stat        (dp_stat),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .sample_in   ($signed(req_tdata[15:0])),
      .velocity_in (req_tdata[31:16]),
      .gate        (req_tuser[0]),
      .sample_out  (sample_out),
      .phase_out   (phase_out),
      .chunk_last  (rsp_tlast),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready)
   );

   assign rsp_tdata = {6'b0, phase_out, sample_out};

   // a present beat keeps the sequencer busy on the next cycle
   `ASR_ASSERT_NEXT(a_busy_after_load, clock, reset, req_tvalid && req_tready && req_tuser[1], !req_tready)
   // the output register is written only when it is free
   `ASR_ASSERT_NOW(a_fin_when_free, clock, reset, ctrl_cmd.fin, dp_stat.out_free)
   // a response only appears after a finish step
   `ASR_ASSERT_NOW(a_rsp_from_fin, clock, reset, $rose(rsp_tvalid), $past(ctrl_cmd.fin))

endmodule

`default_nettype wire
